// ===== rtl/core/hcrl_pkg.sv =====
// Shared constants and controller/datapath interface types for the hashed
// client rate limiter. Used by every module of the block; no dependencies.
package hcrl_pkg;

    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int MAX_KEY_CHARS_DEF = 15;

    localparam int CHAR_W  = 7;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd3;
    localparam logic [APB_AW-1:0]  ADDR_LIMIT  = 2'd0;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic lookup;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

// ===== rtl/core/hashed_client_rate_limiter.sv =====
// Per-client rate limiter with a direct-mapped hashed slot table. A client
// address enters one character per beat on start while busy is low; the slot
// entry for the character marked last is read into a register at the accepting
// edge and is compared and written back in the following cycle, during which
// busy is high. One result beat follows each last character on
// o_result_valid for exactly one cycle and cannot be stalled. After reset,
// busy stays high while the table is cleared one slot per cycle; configuration
// writes are taken throughout. TABLE_DEPTH must be a power of two.
// Top level: APB configuration register and the controller and datapath.
// Depends on hcrl_pkg, hcrl_ctrl and hcrl_dp.
module hashed_client_rate_limiter
    import hcrl_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF,
    parameter int SLOT_W        = $clog2(TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_last_char,
    input  logic [TIME_W-1:0]  i_now_seconds,
    output logic               o_result_valid,
    output logic               o_allowed,
    output logic [SLOT_W-1:0]  o_slot_index,
    output logic               o_new_entry,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] r_limit;
    t_cmd               cmd;
    t_sts               sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_LIMIT)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_LIMIT: prdata = {{(APB_DW-LIMIT_W){1'b0}}, r_limit};
            default:    prdata = '0;
        endcase
    end

    hcrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_last_char (i_last_char),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    hcrl_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_KEY_CHARS (MAX_KEY_CHARS),
        .SLOT_W        (SLOT_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_char_code    (i_char_code),
        .i_now_seconds  (i_now_seconds),
        .i_limit        (r_limit),
        .o_result_valid (o_result_valid),
        .o_allowed      (o_allowed),
        .o_slot_index   (o_slot_index),
        .o_new_entry    (o_new_entry)
    );

endmodule

// ===== rtl/core/hcrl_ctrl.sv =====
// Controller state machine: clearing pass after reset, idle, and table lookup.
// Depends on hcrl_pkg for the command and status types.
module hcrl_ctrl
    import hcrl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_last_char,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        o_cmd.clear_wr = (r_state == ST_CLEAR);
        o_cmd.accept   = accept;
        o_cmd.lookup   = (r_state == ST_LOOKUP);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && i_last_char) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/hcrl_dp.sv =====
// Datapath: hash accumulator, key buffer, slot table memory, key compare and
// time check. Depends on hcrl_pkg; driven by commands from hcrl_ctrl.
module hcrl_dp
    import hcrl_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF,
    parameter int SLOT_W        = $clog2(TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [TIME_W-1:0]  i_now_seconds,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_result_valid,
    output logic               o_allowed,
    output logic [SLOT_W-1:0]  o_slot_index,
    output logic               o_new_entry
);

    localparam int CNT_W   = $clog2(MAX_KEY_CHARS + 2);
    localparam int KEY_W   = MAX_KEY_CHARS * CHAR_W;
    localparam int ENTRY_W = 1 + KEY_W + TIME_W;
    localparam int SUM_W   = SLOT_W + CHAR_W + 1;

    logic [SLOT_W-1:0]  r_hash;
    logic [SLOT_W-1:0]  n_hash;
    logic [SUM_W-1:0]   hash_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [CHAR_W-1:0]  r_key [MAX_KEY_CHARS];
    logic [KEY_W-1:0]   key_flat;
    logic [TIME_W-1:0]  r_now;
    logic [SLOT_W-1:0]  r_clr_addr;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;

    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [TIME_W-1:0]  rd_time;
    logic [TIME_W-1:0]  diff;
    logic               match;
    logic               refuse;

    assign hash_sum = ({{(SUM_W-SLOT_W){1'b0}}, r_hash} << 5)
                    + {{(SUM_W-SLOT_W){1'b0}}, r_hash}
                    + {{(SUM_W-CHAR_W){1'b0}}, i_char_code};
    assign n_hash   = hash_sum[SLOT_W-1:0];

    always_comb begin
        for (int i = 0; i < MAX_KEY_CHARS; i++) begin
            key_flat[i*CHAR_W +: CHAR_W] = r_key[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.lookup) begin
            r_hash <= '0;
            r_cnt  <= '0;
            for (int i = 0; i < MAX_KEY_CHARS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_hash <= n_hash;
            r_now  <= i_now_seconds;
            for (int i = 0; i < MAX_KEY_CHARS; i++) begin
                if (r_cnt == CNT_W'(i)) begin
                    r_key[i] <= i_char_code;
                end
            end
            if (r_cnt <= CNT_W'(MAX_KEY_CHARS)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == SLOT_W'(TABLE_DEPTH - 1));

    assign rd_valid = r_rd[ENTRY_W-1];
    assign rd_key   = r_rd[TIME_W +: KEY_W];
    assign rd_time  = r_rd[TIME_W-1:0];
    assign diff     = r_now - rd_time;
    assign match    = rd_valid && (r_cnt <= CNT_W'(MAX_KEY_CHARS)) && (rd_key == key_flat);
    assign refuse   = match && (diff[TIME_W-1] || (diff < {{(TIME_W-LIMIT_W){1'b0}}, i_limit}));

    always_comb begin
        if (i_cmd.clear_wr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = i_cmd.lookup && !refuse;
            waddr = r_hash;
            wdata = {1'b1, key_flat, r_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= mem[n_hash];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            o_allowed    <= !refuse;
            o_slot_index <= r_hash;
            o_new_entry  <= !match;
        end
    end

endmodule
